FILE: rtl/bilinear_height_gradient_sampler_top_defines.svh
// Assertion macros for the bilinear height and gradient sampler.
`ifndef BILINEAR_HEIGHT_GRADIENT_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_HEIGHT_GRADIENT_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BHGS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bhgs_pkg.sv
// Shared constants, types and codes of the bilinear height and gradient sampler.
package bhgs_pkg;

  localparam int MAX_MAP_SIZE = 256;
  localparam int FRAC_BITS    = 8;
  localparam int ONE          = 1 << FRAC_BITS;

  localparam int IDX_W     = $clog2(MAX_MAP_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;

  localparam int SIZE_W         = 9;
  localparam int MAP_SIZE_RESET = 256;
  localparam int POS_W          = 18;
  localparam int SAMPLE_W       = 16;
  localparam int HEIGHT_W       = 24;
  localparam int GRAD_W         = 25;

  localparam int CELL_W = POS_W - FRAC_BITS;
  localparam int CMP_W  = CELL_W + 1;

  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int HW_W    = 2 * FRAC_BITS + 1;
  localparam int COEF_W  = WGT_W + 1;
  localparam int HPROD_W = SAMPLE_W + HW_W;
  localparam int GACC_W  = SAMPLE_W + 1 + COEF_W;

  localparam int STEPS  = 4;
  localparam int STEP_W = $clog2(STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN
  } back_state_t;

  typedef struct packed {
    mode_t                mode;
    logic                 wr_en;
    logic [IDX_W-1:0]     x0;
    logic [IDX_W-1:0]     x1;
    logic [IDX_W-1:0]     y0;
    logic [IDX_W-1:0]     y1;
    logic [FRAC_BITS-1:0] u;
    logic [FRAC_BITS-1:0] v;
    logic [SAMPLE_W-1:0]  sample;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic pop;
    logic res_load;
    logic idle;
  } back_status_t;

endpackage

FILE: rtl/bhgs_front.sv
// Front end: map size register, request intake, index clamping and write range check.
module bhgs_front import bhgs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [POS_W-1:0]    pos_x,
  input  logic [POS_W-1:0]    pos_y,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  queue_status_t       q_status,
  output logic                push,
  output req_t                req
);

  logic [SIZE_W-1:0] map_size;
  logic [SIZE_W-1:0] size_act;
  logic [IDX_W-1:0]  size_max;
  logic [CMP_W-1:0]  size_max_ext;
  logic [CMP_W-1:0]  cx;
  logic [CMP_W-1:0]  cy;
  logic [CMP_W-1:0]  cx1;
  logic [CMP_W-1:0]  cy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= SIZE_W'(MAP_SIZE_RESET);
    end else if (cfg_we) begin
      map_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (map_size == '0) begin
      size_act = SIZE_W'(1);
    end else if (map_size > SIZE_W'(MAX_MAP_SIZE)) begin
      size_act = SIZE_W'(MAX_MAP_SIZE);
    end else begin
      size_act = map_size;
    end
  end

  assign size_max     = IDX_W'(size_act - SIZE_W'(1));
  assign size_max_ext = CMP_W'(size_max);

  assign cx  = CMP_W'(pos_x[POS_W-1:FRAC_BITS]);
  assign cy  = CMP_W'(pos_y[POS_W-1:FRAC_BITS]);
  assign cx1 = cx + CMP_W'(1);
  assign cy1 = cy + CMP_W'(1);

  always_comb begin
    req.mode   = mode_t'(mode);
    req.wr_en  = (cx < CMP_W'(size_act)) && (cy < CMP_W'(size_act));
    req.x0     = (cx  > size_max_ext) ? size_max : cx[IDX_W-1:0];
    req.x1     = (cx1 > size_max_ext) ? size_max : cx1[IDX_W-1:0];
    req.y0     = (cy  > size_max_ext) ? size_max : cy[IDX_W-1:0];
    req.y1     = (cy1 > size_max_ext) ? size_max : cy1[IDX_W-1:0];
    req.u      = pos_x[FRAC_BITS-1:0];
    req.v      = pos_y[FRAC_BITS-1:0];
    req.sample = sample_value;
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

endmodule

FILE: rtl/bhgs_queue.sv
// Request queue between the front end and the sampling engine.
module bhgs_queue import bhgs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  req_t          push_data,
  input  logic          pop,
  output req_t          head,
  output queue_status_t status
);

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: rtl/bhgs_back.sv
// Sampling engine: height store, four-read sequencer, weighting pipeline and result register.
module bhgs_back import bhgs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  queue_status_t              q_status,
  input  req_t                       head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [HEIGHT_W-1:0]        height_out,
  output logic signed [GRAD_W-1:0]   grad_x_out,
  output logic signed [GRAD_W-1:0]   grad_y_out,
  output back_status_t               status
);

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rdata;

  back_state_t state;
  back_state_t state_next;
  logic [STEP_W-1:0] cnt;
  req_t work;

  logic slot_free;
  logic issue;
  logic wr_fire;
  logic wr_res;
  logic res_load;
  logic [ADDR_W-1:0] mem_addr;

  logic [WGT_W-1:0]        uw;
  logic [WGT_W-1:0]        vw;
  logic [2*WGT_W-1:0]      hw_full;
  logic signed [COEF_W-1:0] us;
  logic signed [COEF_W-1:0] vs;

  logic                     p1_valid;
  logic                     p1_first;
  logic                     p1_last;
  logic [HW_W-1:0]          hw_coef;
  logic signed [COEF_W-1:0] gx_coef;
  logic signed [COEF_W-1:0] gy_coef;

  logic                     p2_valid;
  logic                     p2_first;
  logic                     p2_last;
  logic [HPROD_W-1:0]       prod_h;
  logic signed [GACC_W-1:0] prod_gx;
  logic signed [GACC_W-1:0] prod_gy;

  logic [HPROD_W-1:0]       acc_h;
  logic signed [GACC_W-1:0] acc_gx;
  logic signed [GACC_W-1:0] acc_gy;
  logic [HPROD_W-1:0]       acc_h_next;
  logic signed [GACC_W-1:0] acc_gx_next;
  logic signed [GACC_W-1:0] acc_gy_next;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_status.empty && slot_free && head.mode == MODE_QUERY) begin
          state_next = B_ISSUE;
        end
      end
      B_ISSUE: begin
        if (cnt == STEP_W'(STEPS - 1)) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (p2_valid && p2_last) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    wr_fire  = 1'b0;
    wr_res   = 1'b0;
    mem_addr = {(cnt[1] ? work.y1 : work.y0), (cnt[0] ? work.x1 : work.x0)};
    case (state)
      B_IDLE: begin
        pop     = !q_status.empty && slot_free;
        wr_res  = pop && head.mode == MODE_WRITE;
        wr_fire = wr_res && head.wr_en;
        if (wr_fire) begin
          mem_addr = {head.y0, head.x0};
        end
      end
      B_ISSUE: issue = 1'b1;
      B_DRAIN: issue = 1'b0;
      default: issue = 1'b0;
    endcase
    res_load = wr_res || (p2_valid && p2_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[mem_addr] <= head.sample;
    end
    rdata <= mem[mem_addr];
  end

  always_comb begin
    uw      = cnt[0] ? WGT_W'(work.u) : WGT_W'(ONE) - WGT_W'(work.u);
    vw      = cnt[1] ? WGT_W'(work.v) : WGT_W'(ONE) - WGT_W'(work.v);
    hw_full = uw * vw;
    us      = signed'({1'b0, uw});
    vs      = signed'({1'b0, vw});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= (cnt == '0);
    p1_last  <= (cnt == STEP_W'(STEPS - 1));
    hw_coef  <= hw_full[HW_W-1:0];
    gx_coef  <= cnt[0] ? vs : -vs;
    gy_coef  <= cnt[1] ? us : -us;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    prod_h   <= rdata * hw_coef;
    prod_gx  <= signed'({1'b0, rdata}) * gx_coef;
    prod_gy  <= signed'({1'b0, rdata}) * gy_coef;
  end

  always_comb begin
    acc_h_next  = (p2_first ? '0 : acc_h) + prod_h;
    acc_gx_next = (p2_first ? '0 : acc_gx) + prod_gx;
    acc_gy_next = (p2_first ? '0 : acc_gy) + prod_gy;
  end

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      acc_h  <= acc_h_next;
      acc_gx <= acc_gx_next;
      acc_gy <= acc_gy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (wr_res) begin
        height_out <= '0;
        grad_x_out <= '0;
        grad_y_out <= '0;
      end else begin
        height_out <= acc_h_next[FRAC_BITS +: HEIGHT_W];
        grad_x_out <= acc_gx_next[GRAD_W-1:0];
        grad_y_out <= acc_gy_next[GRAD_W-1:0];
      end
    end
  end

  assign status.pop      = pop;
  assign status.res_load = res_load;
  assign status.idle     = (state == B_IDLE);

endmodule

FILE: rtl/bilinear_height_gradient_sampler_top.sv
// Top level of the bilinear height and gradient sampler.
// Requests enter a two-deep queue at up to one per cycle. The sampling engine
// takes one request at a time from the queue. A write stores its sample in
// the single-port height store if it lies inside the map and returns zeros;
// its result is registered in the cycle after the engine takes it. A query
// reads the four neighbours through that one store port, one per cycle, then
// weights and sums them in a two-stage multiply-accumulate pipe, and the next
// request is taken as the query's result leaves. Writes are taken one per cycle
// while the result side does not stall. The store powers up undefined; read only
// samples written since reset. Write map_size only while the block is idle.
`include "bilinear_height_gradient_sampler_top_defines.svh"

module bilinear_height_gradient_sampler_top import bhgs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [POS_W-1:0]         pos_x,
  input  logic [POS_W-1:0]         pos_y,
  input  logic [SAMPLE_W-1:0]      sample_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [HEIGHT_W-1:0]      height_out,
  output logic signed [GRAD_W-1:0] grad_x_out,
  output logic signed [GRAD_W-1:0] grad_y_out
);

  logic          push;
  logic          pop;
  req_t          push_req;
  req_t          head;
  queue_status_t q_status;
  back_status_t  bk_status;

  bhgs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .sample_value (sample_value),
    .q_status     (q_status),
    .push         (push),
    .req          (push_req)
  );

  bhgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_req),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bhgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .height_out (height_out),
    .grad_x_out (grad_x_out),
    .grad_y_out (grad_y_out),
    .status     (bk_status)
  );

  `BHGS_ASSERT_IMPL(a_pop_idle, clk, rst, bk_status.pop, bk_status.idle && !q_status.empty, "pop outside idle or from empty queue")
  `BHGS_ASSERT_IMPL(a_load_free, clk, rst, bk_status.res_load, !out_valid || !out_stall, "result register overwritten")
  `BHGS_ASSERT_NEXT(a_pop_room, clk, rst, bk_status.pop && !q_status.full, !q_status.full, "queue filled across a pop")

endmodule
